@@ hdl/mbavg_pkg.sv @@
// Shared types and codes for the multichannel boxcar averager.
`timescale 1ns / 1ps

package mbavg_pkg;

    typedef enum logic
    {
        ST_IDLE,
        ST_READ
    } state_t;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    localparam int SAMPLE_FIELD_BITS  = 12;
    localparam int CHANNEL_FIELD_BITS = 8;
    localparam int AVERAGE_FIELD_BITS = 12;
    localparam int IN_DATA_BITS       = 24;
    localparam int OUT_DATA_BITS      = 16;

endpackage

@@ hdl/multichannel_boxcar_averager_unit.sv @@
// Top level: multichannel boxcar averager with per-channel running sums.
//
//  Port group  Dir  Carries
//  s_axis      in   tdata = sample[11:0], channel[19:12], zero pad; tuser = kind
//  m_axis      out  tdata = average[11:0], zero pad
//
// Each item is accepted while the memories are read (the sample store only for a
// sample), then read-modify-write of the sample entry and channel sum (or load of the
// result register for a query). The registered reads of the memories set this order.
// A query waits in the read state while the result register is still full.
// Reset is immediate: the store reads as zero until the write position wraps.
`timescale 1ns / 1ps

module multichannel_boxcar_averager_unit
    import mbavg_pkg::*;
#(
    parameter int CHANNELS    = 8,
    parameter int AVERAGES    = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,   // sample[11:0], channel[19:12]
    input  logic [0:0]               s_tuser,   // kind[0]
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata    // average[11:0]
);

    localparam int DEPTH    = CHANNELS * AVERAGES;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LOG_A    = $clog2(AVERAGES);
    localparam int SUM_W    = SAMPLE_BITS + LOG_A;
    localparam int SHIFT    = SUM_W + LOG_A;
    localparam int RECIP_W  = SUM_W + 1;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(AVERAGES) - 64'd1) / 64'(AVERAGES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    state_t                       state_reg, state_next;
    logic   [ADDR_W-1:0]          wp_reg, wp_next;
    logic   [CH_W-1:0]            wch_reg, wch_next;
    logic                         full_reg, full_next;
    logic                         kind_reg, kind_next;
    logic   [SAMPLE_BITS-1:0]     sample_reg, sample_next;
    logic                         in_range_reg, in_range_next;
    logic                         out_valid_reg, out_valid_next;
    logic   [AVERAGE_FIELD_BITS-1:0] out_avg_reg, out_avg_next;

    logic   [SAMPLE_FIELD_BITS-1:0]  in_sample;
    logic   [CHANNEL_FIELD_BITS-1:0] in_channel;
    logic                            in_kind;
    logic                            accept;
    logic   [SAMPLE_BITS+SAMPLE_FIELD_BITS-1:0] sample_wide;
    logic   [SAMPLE_BITS-1:0]                   in_sample_cut;

    logic                     smp_we, smp_re;
    logic [SAMPLE_BITS-1:0]   smp_rdata;
    logic                     sum_we, sum_re;
    logic [CH_W-1:0]          sum_raddr;
    logic [SUM_W-1:0]         sum_rdata, sum_wdata;
    logic [SAMPLE_BITS-1:0]   old_sample;

    logic [PROD_W-1:0]        product;
    logic [SAMPLE_BITS-1:0]   mean;
    logic [SAMPLE_BITS+AVERAGE_FIELD_BITS-1:0] mean_wide;

    assign in_sample  = s_tdata[SAMPLE_FIELD_BITS-1:0];
    assign in_channel = s_tdata[SAMPLE_FIELD_BITS +: CHANNEL_FIELD_BITS];
    assign in_kind    = s_tuser[0];
    assign accept     = s_tvalid && s_tready;

    // keep only the low SAMPLE_BITS of the reading
    assign sample_wide   = {{SAMPLE_BITS{1'b0}}, in_sample};
    assign in_sample_cut = sample_wide[SAMPLE_BITS-1:0];

    // entry at the write position is unwritten until the first wrap
    assign old_sample = full_reg ? smp_rdata : '0;
    assign sum_wdata  = sum_rdata - SUM_W'(old_sample) + SUM_W'(sample_reg);

    // divide by AVERAGES through a rounded-up reciprocal
    assign product   = PROD_W'(sum_rdata) * PROD_W'(RECIP);
    assign mean      = product[SHIFT +: SAMPLE_BITS];
    assign mean_wide = {{AVERAGE_FIELD_BITS{1'b0}}, mean};

    assign sum_raddr = (in_kind == KIND_QUERY) ? in_channel[CH_W-1:0] : wch_reg;

    mbavg_sample_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (SAMPLE_BITS)
    ) u_sample_mem (
        .clk   (clk),
        .we    (smp_we),
        .waddr (wp_reg),
        .wdata (sample_reg),
        .re    (smp_re),
        .raddr (wp_reg),
        .rdata (smp_rdata)
    );

    mbavg_sum_mem #(
        .ENTRIES (CHANNELS),
        .ADDR_W  (CH_W),
        .DATA_W  (SUM_W)
    ) u_sum_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (sum_we),
        .waddr (wch_reg),
        .wdata (sum_wdata),
        .re    (sum_re),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            wch_reg       <= '0;
            full_reg      <= 1'b0;
            kind_reg      <= KIND_SAMPLE;
            in_range_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            wch_reg       <= wch_next;
            full_reg      <= full_next;
            kind_reg      <= kind_next;
            in_range_reg  <= in_range_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        out_avg_reg <= out_avg_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        wch_next       = wch_reg;
        full_next      = full_reg;
        kind_next      = kind_reg;
        sample_next    = sample_reg;
        in_range_next  = in_range_reg;
        out_valid_next = out_valid_reg;
        out_avg_next   = out_avg_reg;
        s_tready       = 1'b0;
        smp_we         = 1'b0;
        smp_re         = 1'b0;
        sum_we         = 1'b0;
        sum_re         = 1'b0;

        // drop the result once the transfer completes
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    smp_re        = (in_kind == KIND_SAMPLE);
                    sum_re        = 1'b1;
                    kind_next     = in_kind;
                    sample_next   = in_sample_cut;
                    in_range_next = (32'(in_channel) < CHANNELS);
                    state_next    = ST_READ;
                end
            end
            ST_READ:
            begin
                if (kind_reg == KIND_SAMPLE)
                begin
                    smp_we = 1'b1;
                    sum_we = 1'b1;
                    if (wp_reg == ADDR_W'(DEPTH - 1))
                    begin
                        wp_next   = '0;
                        full_next = 1'b1;
                    end
                    else
                    begin
                        wp_next = wp_reg + 1'b1;
                    end
                    if (wch_reg == CH_W'(CHANNELS - 1))
                    begin
                        wch_next = '0;
                    end
                    else
                    begin
                        wch_next = wch_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_avg_next   = in_range_reg ?
                                     mean_wide[AVERAGE_FIELD_BITS-1:0] : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_BITS-AVERAGE_FIELD_BITS){1'b0}}, out_avg_reg};

    a_sample_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_kind == KIND_SAMPLE) |-> ##2 (wp_reg != $past(wp_reg, 2)))
        else $error("sample transfer did not advance the write position");

    a_query_keeps_wp: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_kind == KIND_QUERY) |-> ##2 (wp_reg == $past(wp_reg, 2)))
        else $error("query moved the write position");

    a_full_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full_reg) |-> (wp_reg == '0))
        else $error("store marked full without a wrap");

    a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_READ && $past(kind_reg) == KIND_QUERY))
        else $error("result produced without a query");

endmodule

@@ hdl/mbavg_sample_mem.sv @@
// Circular sample store: one write port, one registered read port.
`timescale 1ns / 1ps

module mbavg_sample_mem #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7,
    parameter int DATA_W = 12
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] store_mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/mbavg_sum_mem.sv @@
// Per-channel running sum memory; a channel never written reads as zero.
`timescale 1ns / 1ps

module mbavg_sum_mem #(
    parameter int ENTRIES = 8,
    parameter int ADDR_W  = 3,
    parameter int DATA_W  = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0]  sum_mem [ENTRIES];
    logic [DATA_W-1:0]  rdata_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic               rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            sum_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= sum_mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule
